FILE: rtl/fgn_pkg.sv
// ----------------------------------------------------------------------------
// fgn_pkg: shared types and constants for the fractal gradient noise block
// Field widths, register codes, reset values and the corner hash constants.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int COORD_W    = 32;
  localparam int SEED_W     = 32;
  localparam int OCT_W      = 4;
  localparam int AMP_W      = 24;
  localparam int FREQ_W     = 24;
  localparam int PERS_W     = 16;
  localparam int CFG_FRAC   = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GRAD_W     = 9;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SEED      = 3'd0,
    REG_OCTAVES   = 3'd1,
    REG_BASE_AMP  = 3'd2,
    REG_BASE_FREQ = 3'd3,
    REG_PERSIST   = 3'd4
  } cfg_reg_e;

  localparam logic [SEED_W-1:0] SEED_RST = '0;
  localparam logic [OCT_W-1:0]  OCT_RST  = 4'd4;
  localparam logic [AMP_W-1:0]  AMP_RST  = 24'd65536;
  localparam logic [FREQ_W-1:0] FREQ_RST = 24'd65536;
  localparam logic [PERS_W-1:0] PERS_RST = 16'd32768;

  // Lattice hash weights for x and y
  localparam logic [31:0] HASH_KX = 32'd67;
  localparam logic [31:0] HASH_KY = 32'd71;

  // Hash input offsets of the four cell corners: (0,0) (1,0) (0,1) (1,1)
  localparam logic [31:0] CORNER_OFF [4] = '{32'd0, HASH_KX, HASH_KY, HASH_KX + HASH_KY};

endpackage

FILE: rtl/fractal_gradient_noise_2d_top.sv
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d_top: fractal 2D gradient noise over 1..MAX_OCTAVES octaves
// Each octave is a lane of its own pipeline; lanes are summed and saturated.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while m_axis_tready is high and the amplitude
//   table is not refilling; all octaves run side by side in parallel lanes.
// Reset: registers take their defaults, the pipeline empties, and the input is
//   held off while the per-octave amplitude table fills.
// The same refill follows a nonzero write to base_amplitude or persistence.
module fractal_gradient_noise_2d_top #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fgn_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [fgn_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [63:0]                       s_axis_tdata,   // coord_x, coord_y
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata    // noise_sum
);

  localparam int T    = FRAC_BITS;
  localparam int L    = 16;
  localparam int PW   = T + 32;
  localparam int BXW  = 41;
  localparam int DW   = T + 11;
  localparam int LW   = DW + T + 3;
  localparam int UW   = T + 11;
  localparam int K    = T + 20;
  localparam int MW   = K - 7;
  localparam int VW   = T + 4;
  localparam int TW   = fgn_pkg::AMP_W + 1 + VW - fgn_pkg::CFG_FRAC;
  localparam int NG   = (MAX_OCTAVES + 3) / 4;
  localparam int SWB  = TW + $clog2(MAX_OCTAVES) + 1;
  localparam int SW   = (SWB > 33) ? SWB : 33;
  localparam int CW   = $clog2(MAX_OCTAVES + 1);

  localparam logic signed [UW:0] BIAS  = (UW+1)'(64'd127 + 64'd255 * (64'd1 << (T + 2)));
  localparam logic [MW-1:0]      RECIP = MW'(((64'd1 << K) + 64'd254) / 64'd255);
  localparam logic [VW-1:0]      VB    = VW'(64'd1 << (T + 2));
  localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SMIN = SW'(-64'sd2147483648);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [fgn_pkg::SEED_W-1:0] seed_q;
  logic [fgn_pkg::OCT_W-1:0]  oct_q;
  logic [fgn_pkg::AMP_W-1:0]  bamp_q;
  logic [fgn_pkg::FREQ_W-1:0] bfreq_q;
  logic [fgn_pkg::PERS_W-1:0] pers_q;
  logic                       rb_start_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= fgn_pkg::SEED_RST;
      oct_q   <= fgn_pkg::OCT_RST;
      bamp_q  <= fgn_pkg::AMP_RST;
      bfreq_q <= fgn_pkg::FREQ_RST;
      pers_q  <= fgn_pkg::PERS_RST;
    end else if (cfg_we_i) begin
      unique case (fgn_pkg::cfg_reg_e'(cfg_addr_i))
        fgn_pkg::REG_SEED: seed_q <= cfg_data_i;
        fgn_pkg::REG_OCTAVES: begin
          if (cfg_data_i[3:0] != '0) oct_q <= cfg_data_i[3:0];
        end
        fgn_pkg::REG_BASE_AMP: begin
          if (cfg_data_i[23:0] != '0) bamp_q <= cfg_data_i[23:0];
        end
        fgn_pkg::REG_BASE_FREQ: begin
          if (cfg_data_i[23:0] != '0) bfreq_q <= cfg_data_i[23:0];
        end
        fgn_pkg::REG_PERSIST: begin
          if (cfg_data_i[15:0] != '0) pers_q <= cfg_data_i[15:0];
        end
        default: ;
      endcase
    end
  end

  assign rb_start_w = cfg_we_i &&
    (((fgn_pkg::cfg_reg_e'(cfg_addr_i) == fgn_pkg::REG_BASE_AMP) && (cfg_data_i[23:0] != '0)) ||
     ((fgn_pkg::cfg_reg_e'(cfg_addr_i) == fgn_pkg::REG_PERSIST) && (cfg_data_i[15:0] != '0)));

  // --------------------------------------------------------------------------
  // Amplitude table: entry k = base_amplitude scaled k times by persistence
  // --------------------------------------------------------------------------
  logic                       busy_q;
  logic [CW-1:0]              cnt_q;
  logic [fgn_pkg::AMP_W-1:0]  run_q;
  logic [fgn_pkg::AMP_W-1:0]  amp_q [MAX_OCTAVES];
  logic [fgn_pkg::AMP_W+fgn_pkg::PERS_W-1:0] ampm_w;
  logic [fgn_pkg::AMP_W-1:0]  amp_nx_w;

  assign ampm_w   = run_q * pers_q;
  assign amp_nx_w = (cnt_q == '0) ? bamp_q
                  : ampm_w[fgn_pkg::AMP_W+fgn_pkg::PERS_W-1:fgn_pkg::CFG_FRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (rb_start_w) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CW'(MAX_OCTAVES - 1)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      run_q <= amp_nx_w;
      for (int k = 0; k < MAX_OCTAVES; k++) begin
        if (cnt_q == CW'(k)) amp_q[k] <= amp_nx_w;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its beat moves on
  // --------------------------------------------------------------------------
  logic [L-1:0] v_q;
  logic [L-1:0] en_w;

  always_comb begin
    en_w[L-1] = ~v_q[L-1] | m_axis_tready;
    for (int k = L - 2; k >= 0; k--) begin
      en_w[k] = ~v_q[k] | en_w[k+1];
    end
  end

  assign s_axis_tready = en_w[0] & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_w[0]) v_q[0] <= s_axis_tvalid & ~busy_q;
      for (int k = 1; k < L; k++) begin
        if (en_w[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 0-1: capture and scale by base_frequency
  // --------------------------------------------------------------------------
  logic signed [31:0]    x0_q, y0_q;
  logic signed [56:0]    mx_w, my_w;
  logic signed [BXW-1:0] bx_q, by_q;

  assign mx_w = x0_q * signed'({1'b0, bfreq_q});
  assign my_w = y0_q * signed'({1'b0, bfreq_q});

  always_ff @(posedge clk_i) begin
    if (en_w[0]) begin
      x0_q <= s_axis_tdata[31:0];
      y0_q <= s_axis_tdata[63:32];
    end
    if (en_w[1]) begin
      bx_q <= mx_w[56:fgn_pkg::CFG_FRAC];
      by_q <= my_w[56:fgn_pkg::CFG_FRAC];
    end
  end

  // --------------------------------------------------------------------------
  // Hash helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] hash_front(input logic [31:0] a, input logic [31:0] sd);
    logic [31:0] h;
    h = a - ((a + sd) << 6);
    return h ^ 32'($signed(h) >>> 17);
  endfunction

  function automatic logic [31:0] hash_back(input logic [31:0] a);
    logic [31:0] h;
    h = a - (a << 9);
    h = h ^ (h << 4);
    h = h - (h << 3);
    h = h ^ (h << 10);
    return h ^ 32'($signed(h) >>> 15);
  endfunction

  // 2h - 255 as a 9-bit signed value
  function automatic logic signed [fgn_pkg::GRAD_W-1:0] grad_of(input logic [7:0] h);
    return signed'({~h[7], h[6:0], 1'b1});
  endfunction

  // --------------------------------------------------------------------------
  // Octave lanes: stages 2-12
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] term_w [NG*4];

  for (genvar ln = 0; ln < MAX_OCTAVES; ln++) begin : g_lane
    logic [PW-1:0]        px_w, py_w;
    logic [2*T-1:0]       fxsq_w, fysq_w;
    logic [31:0]          base_d, base_q;
    logic [T-1:0]         fx2_q, fy2_q, sqx_q, sqy_q;
    logic [T+1:0]         kx_w, ky_w;
    logic [2*T+1:0]       ex_w, ey_w;
    logic [T-1:0]         fx3_q, fy3_q, fx4_q, fy4_q;
    logic [T:0]           wx3_q, wy3_q, wx4_q, wy4_q, wx5_q, wy5_q, wy6_q, wy7_q;
    logic [31:0]          hp_d [4];
    logic [31:0]          hp_q [4];
    logic [31:0]          hh_w [4];
    logic signed [fgn_pkg::GRAD_W-1:0] gx_d [4];
    logic signed [fgn_pkg::GRAD_W-1:0] gy_d [4];
    logic signed [fgn_pkg::GRAD_W-1:0] gx_q [4];
    logic signed [fgn_pkg::GRAD_W-1:0] gy_q [4];
    logic signed [T:0]    fxp_w, fyp_w, fxm_w, fym_w;
    logic signed [T+9:0]  pr_w [8];
    logic signed [DW-1:0] dot_d [4];
    logic signed [DW-1:0] dot_q [4];
    logic signed [DW:0]   df0_w, df1_w, df2_w;
    logic signed [T+1:0]  wxs_w, wys_w;
    logic signed [LW-1:0] lp0_d, lp1_d, lp0_q, lp1_q, pd_d, pd_q;
    logic signed [DW-1:0] lo0_q, lo1_q, a7_d, b7_d, a7_q, b7_q, a8_q, n_w;
    logic signed [UW:0]   us_w;
    logic [UW-1:0]        u9_q;
    logic [UW+MW-1:0]     rp_d, rp_q;
    logic signed [VW-1:0] val_q;
    logic signed [fgn_pkg::AMP_W+VW:0] tp_w;
    logic signed [TW-1:0] term_d, term_q;

    always_comb begin
      // stage 2: lattice cell, fraction, corner hash base, fraction squared
      px_w   = PW'(bx_q) << ln;
      py_w   = PW'(by_q) << ln;
      base_d = px_w[PW-1:T] * fgn_pkg::HASH_KX + py_w[PW-1:T] * fgn_pkg::HASH_KY;
      fxsq_w = px_w[T-1:0] * px_w[T-1:0];
      fysq_w = py_w[T-1:0] * py_w[T-1:0];
      // stage 3: ease weights, hash front half
      kx_w = (T+2)'(3 << T) - (T+2)'({fx2_q, 1'b0});
      ky_w = (T+2)'(3 << T) - (T+2)'({fy2_q, 1'b0});
      ex_w = sqx_q * kx_w;
      ey_w = sqy_q * ky_w;
      for (int c = 0; c < 4; c++) begin
        hp_d[c] = hash_front(base_q + fgn_pkg::CORNER_OFF[c], seed_q);
        // stage 4: hash back half, gradients
        hh_w[c] = hash_back(hp_q[c]);
        gx_d[c] = grad_of(hh_w[c][7:0]);
        gy_d[c] = grad_of(hh_w[c][15:8]);
      end
      // stage 5: corner dot products
      fxp_w = signed'({1'b0, fx4_q});
      fyp_w = signed'({1'b0, fy4_q});
      fxm_w = signed'({1'b1, fx4_q});
      fym_w = signed'({1'b1, fy4_q});
      pr_w[0] = gx_q[0] * fxp_w;
      pr_w[1] = gy_q[0] * fyp_w;
      pr_w[2] = gx_q[1] * fxm_w;
      pr_w[3] = gy_q[1] * fyp_w;
      pr_w[4] = gx_q[2] * fxp_w;
      pr_w[5] = gy_q[2] * fym_w;
      pr_w[6] = gx_q[3] * fxm_w;
      pr_w[7] = gy_q[3] * fym_w;
      for (int c = 0; c < 4; c++) begin
        dot_d[c] = pr_w[2*c] + pr_w[2*c+1];
      end
      // stage 6: x blend products
      wxs_w = signed'({1'b0, wx5_q});
      df0_w = dot_q[1] - dot_q[0];
      df1_w = dot_q[3] - dot_q[2];
      lp0_d = df0_w * wxs_w;
      lp1_d = df1_w * wxs_w;
      // stage 7: x blend sums
      a7_d = lo0_q + DW'(signed'(lp0_q[LW-1:T]));
      b7_d = lo1_q + DW'(signed'(lp1_q[LW-1:T]));
      // stage 8: y blend product
      wys_w = signed'({1'b0, wy7_q});
      df2_w = b7_q - a7_q;
      pd_d  = df2_w * wys_w;
      // stage 9: y blend sum, round offset and bias to keep the divide unsigned
      n_w  = a8_q + DW'(signed'(pd_q[LW-1:T]));
      us_w = BIAS + n_w;
      // stage 10: divide by 255 through the reciprocal
      rp_d = u9_q * RECIP;
      // stage 12: weight by the octave amplitude, drop unused octaves
      tp_w   = signed'({1'b0, amp_q[ln]}) * val_q;
      term_d = (oct_q > 4'(ln)) ? tp_w[fgn_pkg::AMP_W+VW:fgn_pkg::CFG_FRAC] : '0;
    end

    always_ff @(posedge clk_i) begin
      if (en_w[2]) begin
        base_q <= base_d;
        fx2_q  <= px_w[T-1:0];
        fy2_q  <= py_w[T-1:0];
        sqx_q  <= fxsq_w[2*T-1:T];
        sqy_q  <= fysq_w[2*T-1:T];
      end
      if (en_w[3]) begin
        hp_q  <= hp_d;
        fx3_q <= fx2_q;
        fy3_q <= fy2_q;
        wx3_q <= ex_w[2*T:T];
        wy3_q <= ey_w[2*T:T];
      end
      if (en_w[4]) begin
        gx_q  <= gx_d;
        gy_q  <= gy_d;
        fx4_q <= fx3_q;
        fy4_q <= fy3_q;
        wx4_q <= wx3_q;
        wy4_q <= wy3_q;
      end
      if (en_w[5]) begin
        dot_q <= dot_d;
        wx5_q <= wx4_q;
        wy5_q <= wy4_q;
      end
      if (en_w[6]) begin
        lo0_q <= dot_q[0];
        lo1_q <= dot_q[2];
        lp0_q <= lp0_d;
        lp1_q <= lp1_d;
        wy6_q <= wy5_q;
      end
      if (en_w[7]) begin
        a7_q  <= a7_d;
        b7_q  <= b7_d;
        wy7_q <= wy6_q;
      end
      if (en_w[8]) begin
        a8_q <= a7_q;
        pd_q <= pd_d;
      end
      if (en_w[9])  u9_q   <= us_w[UW-1:0];
      if (en_w[10]) rp_q   <= rp_d;
      if (en_w[11]) val_q  <= signed'(rp_q[UW+MW-1:K] - VB);
      if (en_w[12]) term_q <= term_d;
    end

    assign term_w[ln] = term_q;
  end

  for (genvar ln = MAX_OCTAVES; ln < NG * 4; ln++) begin : g_pad
    assign term_w[ln] = '0;
  end

  // --------------------------------------------------------------------------
  // Stages 13-15: group sums, total, saturate
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] grp_d [NG];
  logic signed [SW-1:0] grp_q [NG];
  logic signed [SW-1:0] sum_d, sum_q;
  logic [31:0]          out_d, out_q;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < 4; j++) begin
        grp_d[g] = grp_d[g] + SW'(term_w[g*4+j]);
      end
    end
    sum_d = '0;
    for (int g = 0; g < NG; g++) begin
      sum_d = sum_d + grp_q[g];
    end
    if (sum_q > SMAX) begin
      out_d = SMAX[31:0];
    end else if (sum_q < SMIN) begin
      out_d = SMIN[31:0];
    end else begin
      out_d = sum_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w[13]) grp_q <= grp_d;
    if (en_w[14]) sum_q <= sum_d;
    if (en_w[15]) out_q <= out_d;
  end

  assign m_axis_tvalid = v_q[L-1];
  assign m_axis_tdata  = out_q;

`ifndef ASSERT_OFF
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready)
    else $error("input taken while amplitude table refills");

  a_table_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> (amp_q[0] == bamp_q))
    else $error("amplitude table entry 0 differs from base amplitude");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted beat missing from first stage");

  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !v_q[L-2]) |=> !m_axis_tvalid)
    else $error("output beat repeated");
`endif

endmodule
